[design/awlm_pkg.sv]
// Shared types and constants for the audio window level meter.
// Used by awlm_ctrl, awlm_dp and the top level; depends on nothing.
package awlm_pkg;

    // Input item kinds
    localparam logic [2:0] KIND_SAMPLE  = 3'd0;
    localparam logic [2:0] KIND_TIMEOUT = 3'd1;
    localparam logic [2:0] KIND_ERROR   = 3'd2;
    localparam logic [2:0] KIND_ZERO    = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_WINDOW_MS     = 1'b0;
    localparam logic CFG_RING_CAPACITY = 1'b1;

    // Result kinds
    localparam logic RES_RING   = 1'b0;
    localparam logic RES_REPORT = 1'b1;

    // Iteration counts of the shared arithmetic units
    localparam int MulWidth = 41;   // multiplier bits, magnitude of the window sum
    localparam int DivWidth = 98;   // dividend bits, variance numerator << 16
    localparam int SqrtIter = 32;
    localparam logic [6:0] MulSteps  = 7'(MulWidth);
    localparam logic [6:0] DivSteps  = 7'(DivWidth);
    localparam logic [6:0] SqrtSteps = 7'(SqrtIter);

    typedef enum logic [1:0] {
        DIV_VAR1 = 2'd0,
        DIV_VAR2 = 2'd1,
        DIV_MEAN = 2'd2,
        DIV_PEAK = 2'd3
    } t_div_src;

    typedef struct packed {
        logic     sample_load;
        logic     sample_sq;
        logic     sample_acc;
        logic     cnt_timeout;
        logic     cnt_error;
        logic     cnt_zero;
        logic     tick_load;
        logic     restart;
        logic     mul_start;
        logic     mul_sel_sq;
        logic     mul_step;
        logic     save_a;
        logic     div_start;
        t_div_src div_src;
        logic     div_step;
        logic     sqrt_start;
        logic     sqrt_step;
        logic     save_rms;
        logic     save_mean;
        logic     pk_mul;
        logic     out_ring;
        logic     out_report;
    } t_cmd;

    typedef struct packed {
        logic tick_close;
        logic win_empty;
        logic out_free;
    } t_status;

endpackage

[design/awlm_ctrl.sv]
// Sequencer of the level meter: takes items and steps the datapath units.
// Depends on awlm_pkg for the command and status structs.
module awlm_ctrl import awlm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_kind,
    output logic       o_stall,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_SQ     = 13'b0000000000010,
        S_ACC    = 13'b0000000000100,
        S_EMIT   = 13'b0000000001000,
        S_MUL_A  = 13'b0000000010000,
        S_MUL_B  = 13'b0000000100000,
        S_DIV_V1 = 13'b0000001000000,
        S_DIV_V2 = 13'b0000010000000,
        S_SQRT   = 13'b0000100000000,
        S_DIV_M  = 13'b0001000000000,
        S_PK     = 13'b0010000000000,
        S_DIV_P  = 13'b0100000000000,
        S_REPORT = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic       cnt_zero;

    assign o_stall  = (r_state != S_IDLE);
    assign cnt_zero = (r_cnt == 7'd0);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        KIND_SAMPLE: begin
                            o_cmd.sample_load = 1'b1;
                            n_state = S_SQ;
                        end
                        KIND_TIMEOUT: o_cmd.cnt_timeout = 1'b1;
                        KIND_ERROR:   o_cmd.cnt_error = 1'b1;
                        KIND_ZERO:    o_cmd.cnt_zero = 1'b1;
                        KIND_TICK: begin
                            o_cmd.tick_load = 1'b1;
                            if (i_status.tick_close) begin
                                if (i_status.win_empty) begin
                                    o_cmd.restart = 1'b1;
                                end else begin
                                    o_cmd.mul_start = 1'b1;
                                    n_cnt   = MulSteps;
                                    n_state = S_MUL_A;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SQ: begin
                o_cmd.sample_sq = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.sample_acc = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.out_ring = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_ring = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL_A: begin
                if (!cnt_zero) begin
                    o_cmd.mul_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.save_a     = 1'b1;
                    o_cmd.mul_start  = 1'b1;
                    o_cmd.mul_sel_sq = 1'b1;
                    n_cnt   = MulSteps;
                    n_state = S_MUL_B;
                end
            end
            S_MUL_B: begin
                if (!cnt_zero) begin
                    o_cmd.mul_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_VAR1;
                    n_cnt   = DivSteps;
                    n_state = S_DIV_V1;
                end
            end
            S_DIV_V1: begin
                if (!cnt_zero) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_VAR2;
                    n_cnt   = DivSteps;
                    n_state = S_DIV_V2;
                end
            end
            S_DIV_V2: begin
                if (!cnt_zero) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.sqrt_start = 1'b1;
                    n_cnt   = SqrtSteps;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!cnt_zero) begin
                    o_cmd.sqrt_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.save_rms  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_MEAN;
                    n_cnt   = DivSteps;
                    n_state = S_DIV_M;
                end
            end
            S_DIV_M: begin
                if (!cnt_zero) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.save_mean = 1'b1;
                    o_cmd.pk_mul    = 1'b1;
                    n_state = S_PK;
                end
            end
            S_PK: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DIV_PEAK;
                n_cnt   = DivSteps;
                n_state = S_DIV_P;
            end
            S_DIV_P: begin
                if (!cnt_zero) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.out_report = 1'b1;
                    o_cmd.restart    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 7'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[design/awlm_dp.sv]
// Datapath of the level meter: ring index, window accumulators, event counters,
// shared shift-add multiplier, restoring divider, square root and output register.
// Depends on awlm_pkg; driven by awlm_ctrl.
module awlm_dp import awlm_pkg::*; #(
    parameter int MAX_WINDOW_SAMPLES = 131072,
    parameter int MAX_RING_SLOTS     = 262143
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [31:0] i_slot_word,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [17:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_kind,
    output logic [17:0]        o_ring_index,
    output logic signed [15:0] o_pcm16,
    output logic               o_ring_full,
    output logic [17:0]        o_window_samples,
    output logic [47:0]        o_total_samples,
    output logic signed [31:0] o_mean_q8,
    output logic [30:0]        o_rms_q8,
    output logic [31:0]        o_peak_q8,
    output logic [31:0]        o_read_errors,
    output logic [31:0]        o_read_timeouts,
    output logic [31:0]        o_zero_reads
);

    localparam logic [23:0] MaxSlots  = 24'(MAX_RING_SLOTS);
    localparam logic [17:0] MaxWindow = 18'(MAX_WINDOW_SAMPLES);
    localparam int          AccW      = 82;

    // configuration
    logic [15:0] r_window_ms;
    logic [17:0] r_ring_cap;

    // ring and event state
    logic [17:0] r_write_index;
    logic        r_wrapped;
    logic [47:0] r_total;
    logic [31:0] r_errors, r_timeouts, r_zeros;

    // window state
    logic [17:0]        r_count;
    logic signed [41:0] r_sum;
    logic [63:0]        r_sumsq;
    logic signed [23:0] r_min, r_max;
    logic [15:0]        r_tick;

    // sample in flight
    logic signed [23:0] r_s24;
    logic [23:0]        r_mag;
    logic [47:0]        r_sq;
    logic               r_in_win;
    logic [17:0]        r_ring_slot;
    logic [15:0]        r_ring_pcm;
    logic               r_ring_full;

    // arithmetic units
    logic [AccW-1:0]     r_mc, r_acc, r_a;
    logic [MulWidth-1:0] r_mp;
    logic [DivWidth-1:0] r_dq;
    logic [17:0]         r_rem;
    logic [63:0]         r_sv, r_res, r_bit;
    logic [30:0]         r_rms;
    logic [31:0]         r_mean;
    logic signed [42:0]  r_pmin, r_pmax;

    // output register
    logic        r_out_valid;
    logic        r_o_kind;
    logic [17:0] r_o_index;
    logic [15:0] r_o_pcm;
    logic        r_o_full;
    logic [17:0] r_o_wsamp;
    logic [47:0] r_o_total;
    logic [31:0] r_o_mean;
    logic [30:0] r_o_rms;
    logic [31:0] r_o_peak;
    logic [31:0] r_o_err, r_o_tmo, r_o_zero;

    // ---- ring slot selection ----
    logic [23:0] cap_lim;
    logic [17:0] cap_eff;
    logic        wrap_pre, wrap_post;
    logic [17:0] slot;
    logic [18:0] slot_inc;
    logic signed [23:0] in_s24;
    logic [23:0] in_mag;

    always_comb begin
        cap_lim   = ({6'd0, r_ring_cap} > MaxSlots) ? MaxSlots : {6'd0, r_ring_cap};
        cap_eff   = (cap_lim == 24'd0) ? 18'd1 : cap_lim[17:0];
        wrap_pre  = (r_write_index >= cap_eff);
        slot      = wrap_pre ? 18'd0 : r_write_index;
        slot_inc  = {1'b0, slot} + 19'd1;
        wrap_post = (slot_inc >= {1'b0, cap_eff});
        in_s24    = i_slot_word[31:8];
        in_mag    = in_s24[23] ? (24'd0 - in_s24) : in_s24;
    end

    // ---- tick window close ----
    logic [15:0] tick_inc;
    assign tick_inc = r_tick + 16'd1;
    assign o_status.tick_close = !((tick_inc < r_window_ms) && (tick_inc != 16'd0));
    assign o_status.win_empty  = (r_count == 18'd0);
    assign o_status.out_free   = !r_out_valid || !i_stall;

    // ---- derived close values ----
    logic [41:0]         sum_abs;
    logic [40:0]         s1mag;
    logic [AccW-1:0]     var_diff;
    logic [DivWidth-1:0] div_load;
    logic [63:0]         var_clamped;
    logic signed [43:0]  e_min, e_max;
    logic [43:0]         d_min, d_max, d_pk;
    logic [31:0]         mean_mag;
    logic                rem_nz;

    always_comb begin
        sum_abs     = r_sum[41] ? (42'd0 - r_sum) : r_sum;
        s1mag       = sum_abs[40:0];
        var_diff    = (r_a >= r_acc) ? (r_a - r_acc) : '0;
        var_clamped = (|r_dq[DivWidth-1:64]) ? '1 : r_dq[63:0];
        e_min       = 44'(r_pmin) - 44'(r_sum);
        e_max       = 44'(r_pmax) - 44'(r_sum);
        d_min       = e_min[43] ? (44'd0 - e_min) : e_min;
        d_max       = e_max[43] ? (44'd0 - e_max) : e_max;
        d_pk        = (d_min > d_max) ? d_min : d_max;
        mean_mag    = r_dq[31:0];
        rem_nz      = (r_rem != 18'd0);
        case (i_cmd.div_src)
            DIV_VAR1: div_load = {var_diff, 16'd0};
            DIV_VAR2: div_load = r_dq;
            DIV_MEAN: div_load = {49'd0, s1mag, 8'd0};
            DIV_PEAK: div_load = {46'd0, d_pk, 8'd0};
            default:  div_load = '0;
        endcase
    end

    // divider step: shift in one dividend bit, subtract the count if it fits
    logic [18:0] div_tr;
    logic        div_ge;
    logic [18:0] div_sub;
    assign div_tr  = {r_rem, r_dq[DivWidth-1]};
    assign div_ge  = (div_tr >= {1'b0, r_count});
    assign div_sub = div_tr - {1'b0, r_count};

    // square root step
    logic [63:0] sq_trial;
    logic        sq_ge;
    assign sq_trial = r_res + r_bit;
    assign sq_ge    = (r_sv >= sq_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms   <= 16'd1000;
            r_ring_cap    <= 18'd160000;
            r_write_index <= '0;
            r_wrapped     <= 1'b0;
            r_total       <= '0;
            r_errors      <= '0;
            r_timeouts    <= '0;
            r_zeros       <= '0;
            r_count       <= '0;
            r_sum         <= '0;
            r_sumsq       <= '0;
            r_min         <= 24'sh7FFFFF;
            r_max         <= 24'sh800000;
            r_tick        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WINDOW_MS:     r_window_ms <= i_cfg_data[15:0];
                    CFG_RING_CAPACITY: r_ring_cap  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.sample_load) begin
                r_write_index <= wrap_post ? 18'd0 : slot_inc[17:0];
                r_wrapped     <= r_wrapped | wrap_pre | wrap_post;
                r_total       <= r_total + 48'd1;
            end
            if (i_cmd.cnt_timeout) r_timeouts <= r_timeouts + 32'd1;
            if (i_cmd.cnt_error)   r_errors   <= r_errors + 32'd1;
            if (i_cmd.cnt_zero)    r_zeros    <= r_zeros + 32'd1;
            if (i_cmd.sample_sq && r_in_win) begin
                r_sum   <= r_sum + 42'(r_s24);
                r_count <= r_count + 18'd1;
                if (r_s24 < r_min) r_min <= r_s24;
                if (r_s24 > r_max) r_max <= r_s24;
            end
            if (i_cmd.sample_acc && r_in_win) r_sumsq <= r_sumsq + {16'd0, r_sq};
            if (i_cmd.tick_load) r_tick <= tick_inc;
            if (i_cmd.restart) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
                r_min   <= 24'sh7FFFFF;
                r_max   <= 24'sh800000;
                r_tick  <= '0;
            end
            if (i_cmd.out_ring || i_cmd.out_report) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_load) begin
            r_s24       <= in_s24;
            r_mag       <= in_mag;
            r_in_win    <= (r_count < MaxWindow);
            r_ring_slot <= slot;
            r_ring_pcm  <= i_slot_word[31:16];
            r_ring_full <= r_wrapped | wrap_pre | wrap_post;
        end
        if (i_cmd.sample_sq) r_sq <= r_mag * r_mag;

        if (i_cmd.mul_start) begin
            r_acc <= '0;
            if (i_cmd.mul_sel_sq) begin
                r_mc <= {41'd0, s1mag};
                r_mp <= s1mag;
            end else begin
                r_mc <= {18'd0, r_sumsq};
                r_mp <= {23'd0, r_count};
            end
        end else if (i_cmd.mul_step) begin
            if (r_mp[0]) r_acc <= r_acc + r_mc;
            r_mc <= {r_mc[AccW-2:0], 1'b0};
            r_mp <= {1'b0, r_mp[MulWidth-1:1]};
        end
        if (i_cmd.save_a) r_a <= r_acc;

        if (i_cmd.div_start) begin
            r_dq  <= div_load;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_sub[17:0] : div_tr[17:0];
            r_dq  <= {r_dq[DivWidth-2:0], div_ge};
        end

        if (i_cmd.sqrt_start) begin
            r_sv  <= var_clamped;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (i_cmd.sqrt_step) begin
            if (sq_ge) begin
                r_sv  <= r_sv - sq_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.save_rms) r_rms <= r_res[30:0];
        // floor: negate the magnitude quotient, one lower on a remainder
        if (i_cmd.save_mean) begin
            r_mean <= r_sum[41] ? (~mean_mag + {31'd0, ~rem_nz}) : mean_mag;
        end
        if (i_cmd.pk_mul) begin
            r_pmin <= 43'(r_min) * $signed({25'd0, r_count});
            r_pmax <= 43'(r_max) * $signed({25'd0, r_count});
        end

        if (i_cmd.out_ring) begin
            r_o_kind  <= RES_RING;
            r_o_index <= r_ring_slot;
            r_o_pcm   <= r_ring_pcm;
            r_o_full  <= r_ring_full;
            r_o_wsamp <= '0;
            r_o_total <= '0;
            r_o_mean  <= '0;
            r_o_rms   <= '0;
            r_o_peak  <= '0;
            r_o_err   <= '0;
            r_o_tmo   <= '0;
            r_o_zero  <= '0;
        end else if (i_cmd.out_report) begin
            r_o_kind  <= RES_REPORT;
            r_o_index <= '0;
            r_o_pcm   <= '0;
            r_o_full  <= 1'b0;
            r_o_wsamp <= r_count;
            r_o_total <= r_total;
            r_o_mean  <= r_mean;
            r_o_rms   <= r_rms;
            r_o_peak  <= r_dq[31:0];
            r_o_err   <= r_errors;
            r_o_tmo   <= r_timeouts;
            r_o_zero  <= r_zeros;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_o_kind;
    assign o_ring_index     = r_o_index;
    assign o_pcm16          = r_o_pcm;
    assign o_ring_full      = r_o_full;
    assign o_window_samples = r_o_wsamp;
    assign o_total_samples  = r_o_total;
    assign o_mean_q8        = r_o_mean;
    assign o_rms_q8         = r_o_rms;
    assign o_peak_q8        = r_o_peak;
    assign o_read_errors    = r_o_err;
    assign o_read_timeouts  = r_o_tmo;
    assign o_zero_reads     = r_o_zero;

endmodule

[design/audio_window_level_meter.sv]
// Audio window level meter: ring writes for samples, Q.8 window reports on ticks.
// A sample passes the load, square and accumulate steps, then waits until the
// output register is free; timeout, error, zero-length and tick items that do not
// close a non-empty window are taken without a stall. A tick that closes a
// non-empty window runs the shared shift-add multiplier twice, the restoring
// divider four times and the square root once. Items are taken one at a time;
// configuration is always ready. Depends on awlm_pkg, awlm_ctrl and awlm_dp.
module audio_window_level_meter import awlm_pkg::*; #(
    parameter int MAX_WINDOW_SAMPLES = 131072,
    parameter int MAX_RING_SLOTS     = 262143
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_slot_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [17:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_kind,
    output logic [17:0]        o_ring_index,
    output logic signed [15:0] o_pcm16,
    output logic               o_ring_full,
    output logic [17:0]        o_window_samples,
    output logic [47:0]        o_total_samples,
    output logic signed [31:0] o_mean_q8,
    output logic [30:0]        o_rms_q8,
    output logic [31:0]        o_peak_q8,
    output logic [31:0]        o_read_errors,
    output logic [31:0]        o_read_timeouts,
    output logic [31:0]        o_zero_reads
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    awlm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    awlm_dp #(
        .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES),
        .MAX_RING_SLOTS     (MAX_RING_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_slot_word      (i_slot_word),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_ring_index     (o_ring_index),
        .o_pcm16          (o_pcm16),
        .o_ring_full      (o_ring_full),
        .o_window_samples (o_window_samples),
        .o_total_samples  (o_total_samples),
        .o_mean_q8        (o_mean_q8),
        .o_rms_q8         (o_rms_q8),
        .o_peak_q8        (o_peak_q8),
        .o_read_errors    (o_read_errors),
        .o_read_timeouts  (o_read_timeouts),
        .o_zero_reads     (o_zero_reads)
    );

endmodule

[tb/audio_window_level_meter_test.sv]
// Self-checking testbench for audio_window_level_meter: ring writes and window reports.
// Depends on awlm_pkg and the top level; has its own predictor of the meter.
`timescale 1ns / 1ps

module audio_window_level_meter_test;
    import awlm_pkg::*;

    localparam logic [2:0] KIND_UNUSED5 = 3'd5;
    localparam logic [2:0] KIND_UNUSED6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED7 = 3'd7;
    localparam int WIN_LIMIT   = 131072;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 700;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] word;
    } audio_item_t;

    typedef struct packed {
        logic        rkind;
        logic [17:0] ring_idx;
        logic [15:0] pcm;
        logic        full;
        logic [17:0] win_n;
        logic [47:0] total;
        logic [31:0] mean;
        logic [30:0] rms;
        logic [31:0] peak;
        logic [31:0] errs;
        logic [31:0] touts;
        logic [31:0] zeros;
    } meter_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_kind = '0;
    logic signed [31:0] i_slot_word = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [17:0]        i_cfg_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_result_kind;
    logic [17:0]        o_ring_index;
    logic signed [15:0] o_pcm16;
    logic               o_ring_full;
    logic [17:0]        o_window_samples;
    logic [47:0]        o_total_samples;
    logic signed [31:0] o_mean_q8;
    logic [30:0]        o_rms_q8;
    logic [31:0]        o_peak_q8;
    logic [31:0]        o_read_errors;
    logic [31:0]        o_read_timeouts;
    logic [31:0]        o_zero_reads;

    audio_window_level_meter dut (.*);

    audio_item_t   pending_items[$];
    meter_result_t expected_results[$];
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            fail_count = 0;
    int            cycle_count = 0;

    // predictor state
    logic [15:0]        cfg_window_ms = 16'd1000;
    logic [17:0]        cfg_ring_cap = 18'd160000;
    logic [17:0]        ring_wr_idx = '0;
    logic               ring_wrapped = 1'b0;
    logic [47:0]        total_cnt = '0;
    logic [17:0]        win_cnt = '0;
    logic signed [63:0] win_sum = '0;
    logic [63:0]        win_sumsq = '0;
    int                 win_lo = 8388607;
    int                 win_hi = -8388608;
    logic [15:0]        tick_cnt = '0;
    logic [31:0]        err_cnt = '0;
    logic [31:0]        tout_cnt = '0;
    logic [31:0]        zero_cnt = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic restart_window();
        win_cnt = '0;
        win_sum = '0;
        win_sumsq = '0;
        win_lo = 8388607;
        win_hi = -8388608;
        tick_cnt = '0;
    endtask

    task automatic predict_meter(input logic [2:0] k, input logic [31:0] w);
        meter_result_t      r;
        logic signed [23:0] s24;
        logic signed [63:0] sq, num, mean, n_s, e;
        logic [17:0]        cap;
        logic [127:0]       a, b, d, q;
        logic [63:0]        smag, var_q16, dmin, dmax, peak;
        r = '0;
        case (k)
            KIND_SAMPLE: begin
                s24 = w[31:8];
                cap = (cfg_ring_cap == 0) ? 18'd1 : cfg_ring_cap;
                if (ring_wr_idx >= cap) begin
                    ring_wr_idx = '0;
                    ring_wrapped = 1'b1;
                end
                r.ring_idx = ring_wr_idx;
                ring_wr_idx = ring_wr_idx + 1'b1;
                if (ring_wr_idx >= cap) begin
                    ring_wr_idx = '0;
                    ring_wrapped = 1'b1;
                end
                total_cnt = total_cnt + 1'b1;
                if (win_cnt < WIN_LIMIT) begin
                    sq = s24 * s24;
                    win_sum = win_sum + s24;
                    win_sumsq = win_sumsq + sq;
                    if (s24 < win_lo) win_lo = s24;
                    if (s24 > win_hi) win_hi = s24;
                    win_cnt = win_cnt + 1'b1;
                end
                r.rkind = RES_RING;
                r.pcm = s24[23:8];
                r.full = ring_wrapped;
                expected_results.push_back(r);
            end
            KIND_TIMEOUT: tout_cnt = tout_cnt + 1'b1;
            KIND_ERROR:   err_cnt = err_cnt + 1'b1;
            KIND_ZERO:    zero_cnt = zero_cnt + 1'b1;
            KIND_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                if (!(tick_cnt < cfg_window_ms && tick_cnt != 0)) begin
                    if (win_cnt != 0) begin
                        n_s = 64'(win_cnt);
                        num = win_sum * 256;
                        mean = num / n_s;
                        if (num % n_s != 0 && num < 0) mean = mean - 1;
                        smag = (win_sum < 0) ? 64'(-win_sum) : 64'(win_sum);
                        a = 128'(win_cnt) * 128'(win_sumsq);
                        b = 128'(smag) * 128'(smag);
                        d = (a < b) ? 128'd0 : a - b;
                        d = d << 16;
                        q = (d / 128'(win_cnt)) / 128'(win_cnt);
                        var_q16 = (q[127:64] != 0) ? '1 : q[63:0];
                        e = 64'(win_lo) * n_s - win_sum;
                        dmin = (e < 0) ? 64'(-e) : 64'(e);
                        e = 64'(win_hi) * n_s - win_sum;
                        dmax = (e < 0) ? 64'(-e) : 64'(e);
                        peak = (((dmin > dmax) ? dmin : dmax) * 64'd256) / 64'(win_cnt);
                        r.rkind = RES_REPORT;
                        r.win_n = win_cnt;
                        r.total = total_cnt;
                        r.mean = mean[31:0];
                        r.rms = 31'(isqrt(var_q16));
                        r.peak = peak[31:0];
                        r.errs = err_cnt;
                        r.touts = tout_cnt;
                        r.zeros = zero_cnt;
                        expected_results.push_back(r);
                    end
                    restart_window();
                end
            end
            default: ;
        endcase
    endtask

    // driver: present the head of the pending queue, hold it while stalled
    always @(posedge i_clk) begin : drive_items
        logic busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid && o_stall;
            if (i_valid && !o_stall) begin
                predict_meter(i_kind, i_slot_word);
                void'(pending_items.pop_front());
            end
            if (!busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_kind <= pending_items[0].kind;
                    i_slot_word <= pending_items[0].word;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin : watch_results
        meter_result_t x;
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < stall_pct);
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    x = expected_results.pop_front();
                    check_field("result_kind", 64'(x.rkind), 64'(o_result_kind));
                    check_field("ring_index", 64'(x.ring_idx), 64'(o_ring_index));
                    check_field("pcm16", 64'(x.pcm), 64'($unsigned(o_pcm16)));
                    check_field("ring_full", 64'(x.full), 64'(o_ring_full));
                    check_field("window_samples", 64'(x.win_n), 64'(o_window_samples));
                    check_field("total_samples", 64'(x.total), 64'(o_total_samples));
                    check_field("mean_q8", 64'(x.mean), 64'($unsigned(o_mean_q8)));
                    check_field("rms_q8", 64'(x.rms), 64'(o_rms_q8));
                    check_field("peak_q8", 64'(x.peak), 64'(o_peak_q8));
                    check_field("read_errors", 64'(x.errs), 64'(o_read_errors));
                    check_field("read_timeouts", 64'(x.touts), 64'(o_read_timeouts));
                    check_field("zero_reads", 64'(x.zeros), 64'(o_zero_reads));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_item(input logic [2:0] k, input logic [31:0] w);
        audio_item_t it;
        it.kind = k;
        it.word = w;
        pending_items.push_back(it);
    endtask

    // wait until every item is taken and every result seen, then let the block settle
    task automatic drain();
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [17:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW_MS) cfg_window_ms = value[15:0];
        else cfg_ring_cap = value;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] rand_kind();
        int p;
        p = $urandom_range(99);
        if (p < 60) return KIND_SAMPLE;
        if (p < 85) return KIND_TICK;
        if (p < 88) return KIND_TIMEOUT;
        if (p < 91) return KIND_ERROR;
        if (p < 94) return KIND_ZERO;
        return 3'($urandom_range(KIND_UNUSED7, KIND_UNUSED5));
    endfunction

    task automatic random_phase(input int n_items, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n_items; i++) begin
            push_item(rand_kind(), rand_word());
            // pause the sender halfway until all results are in
            if (i == n_items / 2) begin
                while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
                    @(posedge i_clk);
            end
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // defaults: long window, so ticks only count
        push_item(KIND_SAMPLE, 32'h7FFF_FFFF);
        push_item(KIND_SAMPLE, 32'h8000_0000);
        push_item(KIND_SAMPLE, 32'h0000_0000);
        push_item(KIND_SAMPLE, 32'hFFFF_FFFF);
        push_item(KIND_SAMPLE, 32'h1234_56FF);
        push_item(KIND_TIMEOUT, '0);
        push_item(KIND_ERROR, '0);
        push_item(KIND_ZERO, '0);
        push_item(KIND_UNUSED5, '0);
        push_item(KIND_UNUSED6, '0);
        push_item(KIND_UNUSED7, '1);
        push_item(KIND_TICK, '0);
        drain();

        // zero window length and zero capacity: every tick closes, slot 0 always
        write_reg(CFG_WINDOW_MS, 18'd0);
        write_reg(CFG_RING_CAPACITY, 18'd0);
        push_item(KIND_SAMPLE, 32'h8000_0000);
        push_item(KIND_SAMPLE, 32'h8000_0000);
        push_item(KIND_TICK, '0);
        push_item(KIND_TICK, '0);     // empty window
        push_item(KIND_SAMPLE, 32'h7FFF_FF00);
        push_item(KIND_TICK, '0);
        drain();

        // lower the capacity below the write index: wraps before writing
        write_reg(CFG_WINDOW_MS, 18'd3);
        write_reg(CFG_RING_CAPACITY, 18'd6);
        for (int i = 0; i < 4; i++) push_item(KIND_SAMPLE, $urandom);
        drain();
        write_reg(CFG_RING_CAPACITY, 18'd2);
        push_item(KIND_SAMPLE, 32'h0123_4567);
        push_item(KIND_TICK, '0);
        push_item(KIND_TICK, '0);
        push_item(KIND_TICK, '0);
        drain();

        write_reg(CFG_RING_CAPACITY, 18'h3FFFF);
        write_reg(CFG_WINDOW_MS, 18'd1);
        random_phase(100, 0, 0);
        write_reg(CFG_WINDOW_MS, 18'($urandom_range(6, 2)));
        write_reg(CFG_RING_CAPACITY, 18'($urandom_range(9, 1)));
        random_phase(100, 83, 0);
        write_reg(CFG_WINDOW_MS, 18'($urandom_range(4, 1)));
        write_reg(CFG_RING_CAPACITY, 18'($urandom_range(300, 1)));
        random_phase(100, 0, 83);
        write_reg(CFG_WINDOW_MS, 18'd2);
        write_reg(CFG_RING_CAPACITY, 18'd1);
        random_phase(100, 28, 28);

        // longest window length, no idling: ticks only count
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_WINDOW_MS, 18'hFFFF);
        write_reg(CFG_RING_CAPACITY, 18'd160000);
        for (int i = 0; i < 8; i++) push_item(KIND_SAMPLE, rand_word());
        for (int i = 0; i < 8; i++) push_item(KIND_TICK, '0);
        drain();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
